FILE: src/disjoint_interval_table_macros.svh
// Assertion macros for the interval table modules.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef DISJOINT_INTERVAL_TABLE_MACROS_SVH
`define DISJOINT_INTERVAL_TABLE_MACROS_SVH
// Implication checked every clock, quiet during reset.
`define DIT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
// Next-cycle implication, quiet during reset.
`define DIT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`endif

FILE: src/dit_pkg.sv
// Package for the interval table: sizes, request and status codes, word types.
// No dependencies.
package dit_pkg;
	localparam int MaxIntervals = 64;
	localparam int IdxW = $clog2(MaxIntervals);
	localparam int CntW = $clog2(MaxIntervals + 1);

	localparam logic [2:0] REQ_ADD    = 3'd0;
	localparam logic [2:0] REQ_REMOVE = 3'd1;
	localparam logic [2:0] REQ_FIND   = 3'd2;
	localparam logic [2:0] REQ_SAME   = 3'd3;
	localparam logic [2:0] REQ_FREE   = 3'd4;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [31:0] lo;
		logic [31:0] hi;
	} req_word_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        found;
		logic [31:0] hit_start;
		logic [31:0] hit_end;
		logic        same_flag;
		logic [31:0] free_value;
	} rsp_word_t;
endpackage

FILE: src/dit_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module dit_ram #(
	parameter int Width = 32,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

FILE: src/dit_seq.sv
// Sequencer of the interval table: scans the sorted store, then shifts entries.
// Depends on dit_pkg and on the entry stores (dit_ram) held by the top level.
`include "disjoint_interval_table_macros.svh"
module dit_seq (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    merge_touching,
	input  logic                    start,
	input  dit_pkg::req_word_t      req,
	input  logic [31:0]             rd_start,
	input  logic [31:0]             rd_end,
	output logic [dit_pkg::IdxW-1:0] raddr,
	output logic                    we,
	output logic [dit_pkg::IdxW-1:0] waddr,
	output logic [31:0]             wd_start,
	output logic [31:0]             wd_end,
	output logic                    done,
	output dit_pkg::rsp_word_t      rsp
);
	typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DECIDE, S_UP, S_DOWN, S_NEW, S_FIN}
		state_t;
	localparam int CW = dit_pkg::CntW;
	localparam int IW = dit_pkg::IdxW;

	state_t           state_q;
	dit_pkg::req_word_t req_q;
	logic             mt_q;
	logic [CW-1:0]    cnt_q;
	logic [CW-1:0]    k_q;       // index of entry whose data arrives this cycle
	logic             rvalid_q;  // read data for k_q is valid
	logic [CW-1:0]    a_q, b_q;  // run [a,b) of met entries
	logic             afound_q;
	logic [31:0]      tl_q, tr_q; // first start / last end of run
	logic [31:0]      hs_q, he_q; // last entry with start <= lo
	logic             hhit_q;
	logic [1:0]       nnew_q;
	logic [31:0]      ns0_q, ne0_q, ns1_q, ne1_q;
	logic [CW-1:0]    src_q;     // shift source index
	logic [CW-1:0]    dst_q;     // shift destination index
	logic [CW-1:0]    wcnt_q;    // new entries written
	dit_pkg::rsp_word_t rsp_q;
	logic             done_q;

	logic             is_upd;
	logic [32:0]      end_m, hi_m;
	logic             meet_left, meet_right;
	logic [CW-1:0]    new_cnt;
	logic [CW:0]      tmp_cnt;

	assign is_upd = (req_q.req_type == dit_pkg::REQ_ADD) ||
		(req_q.req_type == dit_pkg::REQ_REMOVE);
	// slack comparisons for the span search
	assign end_m = {1'b0, rd_end} + {32'd0, mt_q && req_q.req_type == dit_pkg::REQ_ADD};
	assign hi_m  = {1'b0, req_q.hi} + {32'd0, mt_q && req_q.req_type == dit_pkg::REQ_ADD};
	assign meet_left  = end_m > {1'b0, req_q.lo};
	assign meet_right = {1'b0, rd_start} < hi_m;
	assign tmp_cnt = {1'b0, cnt_q} - {1'b0, b_q} + {1'b0, a_q} + {{(CW-1){1'b0}}, nnew_q};
	assign new_cnt = tmp_cnt[CW-1:0];

	// read address: next entry during scan (one ahead once data flows),
	// shift source during a move
	always_comb begin
		raddr = k_q[IW-1:0];
		if (state_q == S_SCAN && rvalid_q) raddr = IW'(k_q + 1'b1);
		if (state_q == S_UP || state_q == S_DOWN) raddr = src_q[IW-1:0];
	end

	// sequencer and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			done_q   <= 1'b0;
			rvalid_q <= 1'b0;
			we       <= 1'b0;
		end else begin
			done_q <= 1'b0;
			we     <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						req_q    <= req;
						mt_q     <= merge_touching;
						k_q      <= '0;
						rvalid_q <= 1'b0;
						a_q      <= '0;
						b_q      <= '0;
						afound_q <= 1'b0;
						hhit_q   <= 1'b0;
						rsp_q    <= '0;
						state_q  <= S_SCAN;
					end
				end
				S_SCAN: begin
					// one entry per cycle, read data registered
					if (!rvalid_q) begin
						rvalid_q <= 1'b1;
						if (cnt_q == '0) state_q <= S_DECIDE;
					end else begin
						if (rd_start <= req_q.lo) begin
							hhit_q <= 1'b1;
							hs_q   <= rd_start;
							he_q   <= rd_end;
						end
						if (!afound_q) begin
							if (meet_left) begin
								afound_q <= 1'b1;
								a_q <= k_q;
								if (meet_right) begin
									b_q <= k_q + 1'b1;
									tl_q <= rd_start;
									tr_q <= rd_end;
								end else b_q <= k_q;
							end else begin
								a_q <= k_q + 1'b1;
								b_q <= k_q + 1'b1;
							end
						end else if (b_q == k_q && meet_right) begin
							b_q <= k_q + 1'b1;
							tr_q <= rd_end;
						end
						k_q <= k_q + 1'b1;
						if (k_q + 1'b1 == cnt_q) state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					rvalid_q <= 1'b0;
					state_q  <= S_FIN;
					if (!is_upd) begin
						if (req_q.req_type == dit_pkg::REQ_FIND ||
								req_q.req_type == dit_pkg::REQ_SAME ||
								req_q.req_type == dit_pkg::REQ_FREE) begin
							if (hhit_q && he_q > req_q.lo) begin
								rsp_q.found      <= 1'b1;
								rsp_q.hit_start  <= hs_q;
								rsp_q.hit_end    <= he_q;
								rsp_q.same_flag  <= hs_q <= req_q.hi && req_q.hi < he_q;
								rsp_q.free_value <= he_q;
							end else rsp_q.free_value <= req_q.lo;
						end
					end else if (req_q.lo >= req_q.hi) begin
						rsp_q.status <= dit_pkg::ST_EMPTY;
					end else if (req_q.req_type == dit_pkg::REQ_ADD) begin
						if (a_q == b_q && cnt_q >= CW'(dit_pkg::MaxIntervals)) begin
							rsp_q.status <= dit_pkg::ST_FULL;
						end else begin
							nnew_q <= 2'd1;
							ns0_q <= (a_q != b_q && tl_q < req_q.lo) ? tl_q : req_q.lo;
							ne0_q <= (a_q != b_q && tr_q > req_q.hi) ? tr_q : req_q.hi;
							state_q <= S_NEW;
						end
					end else if (a_q != b_q) begin
						// remove: left and right remnants
						if (tl_q < req_q.lo) begin
							ns0_q <= tl_q;
							ne0_q <= req_q.lo;
							ns1_q <= req_q.hi;
							ne1_q <= tr_q;
							nnew_q <= (req_q.hi < tr_q) ? 2'd2 : 2'd1;
						end else begin
							ns0_q <= req_q.hi;
							ne0_q <= tr_q;
							nnew_q <= (req_q.hi < tr_q) ? 2'd1 : 2'd0;
						end
						state_q <= S_NEW;
					end
				end
				S_NEW: begin
					// flag full if the new count exceeds the table, else choose shift direction for the tail
					if (tmp_cnt > (CW+1)'(dit_pkg::MaxIntervals)) begin
						rsp_q.status <= dit_pkg::ST_FULL;
						state_q <= S_FIN;
					end else if ({1'b0, a_q} + {{(CW-1){1'b0}}, nnew_q} < {1'b0, b_q}) begin
						src_q <= b_q;
						dst_q <= a_q + {{(CW-2){1'b0}}, nnew_q};
						rvalid_q <= 1'b0;
						wcnt_q <= '0;
						state_q <= (b_q == cnt_q) ? S_FIN : S_DOWN;
					end else begin
						src_q <= cnt_q - 1'b1;
						dst_q <= new_cnt - 1'b1;
						rvalid_q <= 1'b0;
						wcnt_q <= '0;
						state_q <= ({1'b0, a_q} + {{(CW-1){1'b0}}, nnew_q} == {1'b0, b_q}
							|| b_q == cnt_q) ? S_FIN : S_UP;
					end
					if (tmp_cnt <= (CW+1)'(dit_pkg::MaxIntervals)) cnt_q <= cnt_q;
				end
				S_DOWN: begin
					// move tail toward the front, low index first
					if (!rvalid_q) begin
						rvalid_q <= 1'b1;
					end else begin
						we       <= 1'b1;
						waddr    <= dst_q[IW-1:0];
						wd_start <= rd_start;
						wd_end   <= rd_end;
						dst_q    <= dst_q + 1'b1;
						src_q    <= src_q + 1'b1;
						rvalid_q <= 1'b0;
						if (src_q + 1'b1 == cnt_q) state_q <= S_FIN;
					end
				end
				S_UP: begin
					// move tail toward the back, high index first
					if (!rvalid_q) begin
						rvalid_q <= 1'b1;
					end else begin
						we       <= 1'b1;
						waddr    <= dst_q[IW-1:0];
						wd_start <= rd_start;
						wd_end   <= rd_end;
						dst_q    <= dst_q - 1'b1;
						src_q    <= src_q - 1'b1;
						rvalid_q <= 1'b0;
						if (src_q == b_q) state_q <= S_FIN;
					end
				end
				S_FIN: begin
					// write new entries one per cycle, then answer
					if (is_upd && rsp_q.status == dit_pkg::ST_DONE &&
							req_q.lo < req_q.hi && (a_q != b_q ||
							req_q.req_type == dit_pkg::REQ_ADD) &&
							wcnt_q < {{(CW-2){1'b0}}, nnew_q}) begin
						we       <= 1'b1;
						waddr    <= IW'(a_q + wcnt_q);
						wd_start <= (wcnt_q == '0) ? ns0_q : ns1_q;
						wd_end   <= (wcnt_q == '0) ? ne0_q : ne1_q;
						wcnt_q   <= wcnt_q + 1'b1;
					end else begin
						if (is_upd && rsp_q.status == dit_pkg::ST_DONE &&
								req_q.lo < req_q.hi && (a_q != b_q ||
								req_q.req_type == dit_pkg::REQ_ADD))
							cnt_q <= new_cnt;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	`DIT_ASSERT_IMP(a_cnt_range, clk, arst_n, 1'b1, cnt_q <= CW'(dit_pkg::MaxIntervals))
	`DIT_ASSERT_IMP(a_run_order, clk, arst_n, state_q == S_NEW, a_q <= b_q && b_q <= cnt_q)
	`DIT_ASSERT_NEXT(a_done_idle, clk, arst_n, done_q, state_q == S_IDLE)
endmodule

FILE: src/disjoint_interval_table.sv
// Top level of the interval table: handshake, output register, entry stores.
// Depends on dit_pkg, dit_ram and dit_seq.
//
//  channel   direction  handshake          payload
//  in        input      in_valid/in_stall  dit_pkg::req_word_t
//  out       output     out_valid/out_stall dit_pkg::rsp_word_t
//  cfg       input      cfg_we             cfg_wdata (merge_touching)
//
// A query scans the table, reading one entry per cycle from the single read
// port, then passes through the decide, finish and answer steps and the
// handshake before the next word is accepted. An add or remove that changes
// the table also moves the T tail entries one at a time and writes the W new
// entries; the table holds at most 64 entries.
// After reset the table is empty and merge_touching is 1.
// A held result stalls the input: no word starts until the result is taken.
module disjoint_interval_table (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  dit_pkg::req_word_t in_word,
	output logic               out_valid,
	input  logic               out_stall,
	output dit_pkg::rsp_word_t out_word
);
	localparam int IW = dit_pkg::IdxW;

	logic             merge_q;
	logic             busy_q;
	logic             start;
	logic [IW-1:0]    raddr, waddr;
	logic             we;
	logic [31:0]      wd_start, wd_end, rd_start, rd_end;
	logic             done;
	dit_pkg::rsp_word_t rsp;

	// accept only when sequencer idle and output slot free
	assign in_stall = busy_q || out_valid;
	assign start    = in_valid && !in_stall;

	// config register, busy flag, output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			merge_q   <= 1'b1;
			busy_q    <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) merge_q <= cfg_wdata;
			if (start) busy_q <= 1'b1;
			if (done) begin
				busy_q    <= 1'b0;
				out_valid <= 1'b1;
				out_word  <= rsp;
			end else if (out_valid && !out_stall) out_valid <= 1'b0;
		end
	end

	dit_seq u_seq (
		.clk, .arst_n, .merge_touching(merge_q), .start, .req(in_word),
		.rd_start, .rd_end, .raddr, .we, .waddr, .wd_start, .wd_end,
		.done, .rsp
	);

	dit_ram #(.Width(32), .Depth(dit_pkg::MaxIntervals)) u_start_ram (
		.clk, .we, .waddr, .wdata(wd_start), .raddr, .rdata(rd_start)
	);
	dit_ram #(.Width(32), .Depth(dit_pkg::MaxIntervals)) u_end_ram (
		.clk, .we, .waddr, .wdata(wd_end), .raddr, .rdata(rd_end)
	);
endmodule

FILE: dv/tb.sv
// Self-checking testbench for disjoint_interval_table: a request driver, a response
// monitor and an interval-table predictor. Depends on dit_pkg and the RTL top level.
`timescale 1ns / 1ps

module tb;
	localparam int WatchdogLimit = 20000;
	localparam int DrainCycles = 600;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic               cfg_wdata;
	logic               in_valid;
	logic               in_stall;
	dit_pkg::req_word_t in_word;
	logic               out_valid;
	logic               out_stall;
	dit_pkg::rsp_word_t out_word;

	disjoint_interval_table dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
		.out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
	);

	// predictor copy of the table
	logic [31:0] iv_start [dit_pkg::MaxIntervals];
	logic [31:0] iv_end [dit_pkg::MaxIntervals];
	int          iv_count;
	logic        merge_mode;

	dit_pkg::req_word_t pending_reqs[$];
	dit_pkg::rsp_word_t expected_rsps[$];
	int          errors;
	bit          quiet_mode;
	int          hold_off;
	int          idle_cycles;

	// replace entries [a,b) by n new ones
	task automatic splice_entries(int a, int b, int n, logic [31:0] s0, logic [31:0] e0,
			logic [31:0] s1, logic [31:0] e1);
		logic [31:0] ts [dit_pkg::MaxIntervals];
		logic [31:0] te [dit_pkg::MaxIntervals];
		int k;
		int m;
		m = 0;
		for (k = 0; k < a; k++) begin
			ts[m] = iv_start[k]; te[m] = iv_end[k]; m++;
		end
		if (n > 0) begin
			ts[m] = s0; te[m] = e0; m++;
		end
		if (n > 1) begin
			ts[m] = s1; te[m] = e1; m++;
		end
		for (k = b; k < iv_count; k++) begin
			ts[m] = iv_start[k]; te[m] = iv_end[k]; m++;
		end
		for (k = 0; k < m; k++) begin
			iv_start[k] = ts[k]; iv_end[k] = te[k];
		end
		iv_count = m;
	endtask

	// apply one request to the table and return the expected response
	task automatic apply_request(input dit_pkg::req_word_t r, output dit_pkg::rsp_word_t o);
		int a;
		int b;
		int h;
		int n;
		logic [32:0] slack;
		logic [31:0] s0, e0, s1, e1;
		o = '0;
		slack = {32'd0, merge_mode};
		if (r.req_type == dit_pkg::REQ_ADD || r.req_type == dit_pkg::REQ_REMOVE) begin
			if (r.lo >= r.hi) begin
				o.status = dit_pkg::ST_EMPTY;
			end else begin
				if (r.req_type == dit_pkg::REQ_REMOVE) slack = '0;
				a = 0;
				while (a < iv_count && !({1'b0, iv_end[a]} + slack > {1'b0, r.lo})) a++;
				b = a;
				while (b < iv_count && {1'b0, iv_start[b]} < {1'b0, r.hi} + slack) b++;
				if (r.req_type == dit_pkg::REQ_ADD) begin
					if (a == b && iv_count >= dit_pkg::MaxIntervals) begin
						o.status = dit_pkg::ST_FULL;
					end else begin
						s0 = r.lo; e0 = r.hi;
						if (a != b) begin
							if (iv_start[a] < s0) s0 = iv_start[a];
							if (iv_end[b - 1] > e0) e0 = iv_end[b - 1];
						end
						splice_entries(a, b, 1, s0, e0, '0, '0);
					end
				end else if (a != b) begin
					n = 0;
					s0 = '0; e0 = '0; s1 = '0; e1 = '0;
					if (iv_start[a] < r.lo) begin
						s0 = iv_start[a]; e0 = r.lo; n++;
					end
					if (r.hi < iv_end[b - 1]) begin
						if (n == 0) begin
							s0 = r.hi; e0 = iv_end[b - 1];
						end else begin
							s1 = r.hi; e1 = iv_end[b - 1];
						end
						n++;
					end
					if (iv_count - (b - a) + n > dit_pkg::MaxIntervals)
						o.status = dit_pkg::ST_FULL;
					else splice_entries(a, b, n, s0, e0, s1, e1);
				end
			end
		end else if (r.req_type == dit_pkg::REQ_FIND || r.req_type == dit_pkg::REQ_SAME
				|| r.req_type == dit_pkg::REQ_FREE) begin
			h = -1;
			for (int k = 0; k < iv_count && iv_start[k] <= r.lo; k++) h = k;
			if (h >= 0 && iv_end[h] > r.lo) begin
				o.found = 1'b1;
				o.hit_start = iv_start[h];
				o.hit_end = iv_end[h];
				o.same_flag = (iv_start[h] <= r.hi && r.hi < iv_end[h]);
				o.free_value = iv_end[h];
			end else begin
				o.free_value = r.lo;
			end
		end
	endtask

	function automatic dit_pkg::req_word_t make_req(logic [2:0] t, logic [31:0] l,
			logic [31:0] h);
		dit_pkg::req_word_t r;
		r.req_type = t; r.lo = l; r.hi = h;
		return r;
	endfunction

	// random request: mostly small coordinates so entries collide
	function automatic dit_pkg::req_word_t random_req(int span_bits);
		logic [31:0] base;
		logic [31:0] l;
		logic [31:0] h;
		int t;
		base = ($urandom_range(0, 9) == 0) ? $urandom : 32'h0;
		l = base + ($urandom & ((32'd1 << span_bits) - 1));
		h = l + $urandom_range(0, 40);
		if ($urandom_range(0, 19) == 0) h = $urandom;
		if ($urandom_range(0, 49) == 0) begin
			l = $urandom; h = 32'hffff_ffff;
		end
		t = $urandom_range(0, 99);
		if (t < 35) return make_req(dit_pkg::REQ_ADD, l, h);
		if (t < 55) return make_req(dit_pkg::REQ_REMOVE, l, h);
		if (t < 70) return make_req(dit_pkg::REQ_FIND, l, h);
		if (t < 84) return make_req(dit_pkg::REQ_SAME, l, l + $urandom_range(0, 30));
		if (t < 98) return make_req(dit_pkg::REQ_FREE, l, h);
		return make_req(3'($urandom_range(5, 7)), $urandom, $urandom);
	endfunction

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// driver: offers queued words, random gaps
	int drive_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_word <= '0;
			drive_gap = 0;
		end else begin
			if (in_valid && !in_stall) begin
				dit_pkg::rsp_word_t e;
				apply_request(in_word, e);
				expected_rsps.push_back(e);
				void'(pending_reqs.pop_front());
			end
			if (!(in_valid && in_stall)) begin
				if (drive_gap > 0) begin
					drive_gap--;
					in_valid <= 1'b0;
				end else if (pending_reqs.size() > 0 && !(in_valid && !in_stall
						&& pending_reqs.size() == 0)) begin
					if (!quiet_mode && $urandom_range(0, 5) == 0) begin
						drive_gap = $urandom_range(0, 3);
						in_valid <= 1'b0;
					end else begin
						in_valid <= 1'b1;
						in_word <= pending_reqs[0];
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor and receiver stall
	int stall_burst;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b1;
			stall_burst = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_rsps.size() == 0) begin
					$display("%0t unexpected response %p", $time, out_word);
					errors++;
				end else begin
					dit_pkg::rsp_word_t e;
					e = expected_rsps.pop_front();
					if (out_word.status !== e.status)
						$display("%0t status exp %0d got %0d", $time, e.status, out_word.status);
					if (out_word.found !== e.found)
						$display("%0t found exp %0d got %0d", $time, e.found, out_word.found);
					if (out_word.hit_start !== e.hit_start)
						$display("%0t hit_start exp %h got %h", $time, e.hit_start,
							out_word.hit_start);
					if (out_word.hit_end !== e.hit_end)
						$display("%0t hit_end exp %h got %h", $time, e.hit_end, out_word.hit_end);
					if (out_word.same_flag !== e.same_flag)
						$display("%0t same_flag exp %0d got %0d", $time, e.same_flag,
							out_word.same_flag);
					if (out_word.free_value !== e.free_value)
						$display("%0t free_value exp %h got %h", $time, e.free_value,
							out_word.free_value);
					if (out_word !== e) errors++;
				end
			end
			// long hold-off requested by stimulus, then random bursts
			if (hold_off > 0) begin
				hold_off--;
				out_stall <= 1'b1;
			end else if (stall_burst > 0) begin
				stall_burst--;
				out_stall <= 1'b1;
			end else if (!quiet_mode && $urandom_range(0, 5) == 0) begin
				stall_burst = $urandom_range(0, 3);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// watchdog: cycles without any handshake
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || hold_off > 0)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WatchdogLimit) begin
			$display("[disjoint_interval_table] ERROR");
			$finish;
		end
	end

	task automatic wait_drained();
		while (pending_reqs.size() > 0 || expected_rsps.size() > 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_merge(logic v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		merge_mode = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// stimulus
	initial begin
		errors = 0;
		quiet_mode = 0;
		hold_off = 0;
		idle_cycles = 0;
		iv_count = 0;
		merge_mode = 1'b1;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, every request, empty and unused codes, split
		pending_reqs.push_back(make_req(dit_pkg::REQ_FIND, 32'd0, 32'd0));
		pending_reqs.push_back(make_req(dit_pkg::REQ_ADD, 32'd10, 32'd10));
		pending_reqs.push_back(make_req(dit_pkg::REQ_REMOVE, 32'd9, 32'd3));
		pending_reqs.push_back(make_req(dit_pkg::REQ_ADD, 32'd10, 32'd20));
		pending_reqs.push_back(make_req(dit_pkg::REQ_ADD, 32'd20, 32'd30));
		pending_reqs.push_back(make_req(dit_pkg::REQ_SAME, 32'd12, 32'd29));
		pending_reqs.push_back(make_req(dit_pkg::REQ_REMOVE, 32'd14, 32'd16));
		pending_reqs.push_back(make_req(dit_pkg::REQ_FREE, 32'd10, 32'd0));
		pending_reqs.push_back(make_req(dit_pkg::REQ_FREE, 32'd15, 32'd0));
		pending_reqs.push_back(make_req(dit_pkg::REQ_REMOVE, 32'd40, 32'd50));
		pending_reqs.push_back(make_req(dit_pkg::REQ_ADD, 32'hffff_fff0, 32'hffff_ffff));
		pending_reqs.push_back(make_req(dit_pkg::REQ_FIND, 32'hffff_fffe, 32'hffff_ffff));
		pending_reqs.push_back(make_req(dit_pkg::REQ_ADD, 32'd0, 32'hffff_ffff));
		pending_reqs.push_back(make_req(dit_pkg::REQ_REMOVE, 32'd0, 32'hffff_ffff));
		pending_reqs.push_back(make_req(3'd5, 32'hffff_ffff, 32'hffff_ffff));
		pending_reqs.push_back(make_req(3'd7, 32'd1, 32'd2));
		wait_drained();

		// fill with separate touching intervals, then hit table full cases
		write_merge(1'b0);
		for (int k = 0; k < dit_pkg::MaxIntervals; k++)
			pending_reqs.push_back(make_req(dit_pkg::REQ_ADD, 32'(k * 4), 32'(k * 4 + 4)));
		pending_reqs.push_back(make_req(dit_pkg::REQ_ADD, 32'd1000, 32'd1001));
		pending_reqs.push_back(make_req(dit_pkg::REQ_REMOVE, 32'd1, 32'd2));
		pending_reqs.push_back(make_req(dit_pkg::REQ_ADD, 32'd2, 32'd3));
		pending_reqs.push_back(make_req(dit_pkg::REQ_SAME, 32'd0, 32'd4));
		// back-pressure: receiver holds off while the sender keeps offering
		hold_off = 300;
		wait_drained();

		// random phases across both merge settings
		for (int phase = 0; phase < 6; phase++) begin
			if (phase == 5) quiet_mode = 1;
			write_merge(phase[0]);
			pending_reqs.push_back(make_req(dit_pkg::REQ_REMOVE, 32'd0, 32'hffff_ffff));
			for (int k = 0; k < 300; k++)
				pending_reqs.push_back(random_req((phase % 3 == 0) ? 6 : 9));
			wait_drained();
		end

		if (errors == 0)
			$display("[disjoint_interval_table] OK");
		else
			$display("[disjoint_interval_table] ERROR");
		$finish;
	end
endmodule

FILE: disjoint_interval_table.f
+incdir+src
src/dit_pkg.sv
src/dit_ram.sv
src/dit_seq.sv
src/disjoint_interval_table.sv
dv/tb.sv
